// ===== sv/rac_pkg.sv =====
// Package for the range allocator: payload words, cell control and report types,
// status and command codes. No dependencies.
package rac_pkg;

   localparam int SLOTS_MAX  = 1024;
   localparam int RANGES_MAX = 512;
   localparam int OFF_W      = 10;
   localparam int CNT_W      = 11;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_SMALL = 2'd1;
   localparam logic [1:0] ST_NO_RANGE  = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [2:0] CMD_HOLD   = 3'd0;
   localparam logic [2:0] CMD_ALLOC  = 3'd1;
   localparam logic [2:0] CMD_LEFT   = 3'd2;
   localparam logic [2:0] CMD_BOTH   = 3'd3;
   localparam logic [2:0] CMD_RIGHT  = 3'd4;
   localparam logic [2:0] CMD_INSERT = 3'd5;

   typedef struct packed {
      logic             req_type;
      logic [CNT_W-1:0] count;
      logic [OFF_W-1:0] range_offset;
   } req_type_type;

   typedef struct packed {
      logic             resp_kind;
      logic [1:0]       status;
      logic [OFF_W-1:0] alloc_offset;
      logic [CNT_W-1:0] free_total;
   } rsp_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic             capture;
      logic             apply;
      logic [2:0]       cmd;
      logic             exact;
      logic [CNT_W-1:0] cnt;
      logic [OFF_W-1:0] off;
      logic             reload;
      logic [CNT_W-1:0] size;
   } ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic             valid;
      logic [OFF_W-1:0] start;
      logic [CNT_W-1:0] len;
      logic             le_q;
      logic             upto_q;
   } nbr_type;

   // per-cell findings, OR-reduced at the top level
   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic             exact;
      logic             right;
      logic             left_gt;
      logic             left_eq;
      logic             right_gt;
      logic             right_eq;
   } rpt_type;

endpackage

// ===== sv/rac_cell.sv =====
// One entry of the sorted free-range table: compares against the request,
// then shifts, shrinks or merges entries with its neighbors. Depends on rac_pkg.
module rac_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             is_first,
   input  rac_pkg::ctl_type ctl,
   input  rac_pkg::nbr_type prev_nbr,
   input  rac_pkg::nbr_type next_nbr,
   input  logic             prev_le_c,
   input  logic             next_le_c,
   input  logic             upto_in,
   output logic             le_c,
   output logic             upto_out,
   output rac_pkg::nbr_type own_nbr,
   output rac_pkg::rpt_type rpt
);
   import rac_pkg::*;

   logic             valid_ff, valid_in;
   logic [OFF_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic             le_ff, upto_ff;
   logic             fit, first, left_c, right_c;
   logic [CNT_W-1:0] end_c;
   logic [CNT_W:0]   off_end;
   logic             is_left, is_right, first_q;

   assign fit      = valid_ff && (len_ff >= ctl.cnt);
   assign le_c     = valid_ff && (start_ff <= ctl.off);
   assign upto_out = upto_in | fit;
   assign first    = fit & ~upto_in;
   assign end_c    = {1'b0, start_ff} + len_ff;
   assign off_end  = {2'b00, ctl.off} + {1'b0, ctl.cnt};
   assign left_c   = le_c & ~next_le_c;
   assign right_c  = valid_ff & ~le_c & prev_le_c;

   always_comb begin
      rpt.offset   = first ? OFF_W'(end_c - ctl.cnt) : '0;
      rpt.exact    = first && (len_ff == ctl.cnt);
      rpt.right    = right_c;
      rpt.left_gt  = left_c && (end_c > {1'b0, ctl.off});
      rpt.left_eq  = left_c && (end_c == {1'b0, ctl.off});
      rpt.right_gt = right_c && (off_end > {2'b00, start_ff});
      rpt.right_eq = right_c && (off_end == {2'b00, start_ff});
   end

   assign own_nbr = '{valid: valid_ff, start: start_ff, len: len_ff,
                      le_q: le_ff, upto_q: upto_ff};

   // positions taken from the flags captured in the compare cycle
   assign is_left  = le_ff & ~next_nbr.le_q;
   assign is_right = ~le_ff & prev_nbr.le_q;
   assign first_q  = upto_ff & ~prev_nbr.upto_q;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      len_in   = len_ff;
      if (ctl.reload) begin
         valid_in = is_first;
         start_in = '0;
         len_in   = is_first ? ctl.size : '0;
      end else if (ctl.apply) begin
         case (ctl.cmd)
            CMD_ALLOC: begin
               if (ctl.exact && upto_ff) begin
                  valid_in = next_nbr.valid;
                  start_in = next_nbr.start;
                  len_in   = next_nbr.len;
               end else if (first_q) begin
                  len_in = len_ff - ctl.cnt;
               end
            end
            CMD_LEFT: begin
               if (is_left) len_in = len_ff + ctl.cnt;
            end
            CMD_BOTH: begin
               if (is_left) begin
                  len_in = len_ff + ctl.cnt + next_nbr.len;
               end else if (!le_ff) begin
                  valid_in = next_nbr.valid;
                  start_in = next_nbr.start;
                  len_in   = next_nbr.len;
               end
            end
            CMD_RIGHT: begin
               if (is_right) begin
                  start_in = ctl.off;
                  len_in   = len_ff + ctl.cnt;
               end
            end
            CMD_INSERT: begin
               if (is_right) begin
                  valid_in = 1'b1;
                  start_in = ctl.off;
                  len_in   = ctl.cnt;
               end else if (!le_ff) begin
                  valid_in = prev_nbr.valid;
                  start_in = prev_nbr.start;
                  len_in   = prev_nbr.len;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= is_first;
         start_ff <= '0;
         len_ff   <= is_first ? CNT_W'(SLOTS_MAX) : '0;
         le_ff    <= 1'b0;
         upto_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         if (ctl.capture) begin
            le_ff   <= le_c;
            upto_ff <= upto_out;
         end
      end
   end

endmodule

// ===== sv/range_allocator_coalescing_top.sv =====
// Top level of the first-fit range allocator: control, totals and the cell row.
// Depends on rac_pkg and rac_cell.
//
//   channel | direction | handshake              | word
//   req_    | in        | req_valid / req_ready  | req_data (kind, count, offset)
//   rsp_    | out       | rsp_valid / rsp_ready  | rsp_data (kind, status, offset, total)
//   csr_    | in        | csr_valid / csr_ready  | csr_wdata (heap size)
//
// Each request is accepted in S_IDLE, compared in all cells with a priority chain
// through the row in S_EVAL, then applied as one shift/merge step of the row in
// S_APPLY. The response word is registered in S_EVAL and set valid at the end of
// S_APPLY; the next request is taken only after the response word has left. A
// configuration write is taken in S_IDLE and reloads the whole row. Reset is synchronous;
// the table holds one range of 1024 slots after it. A stalled response holds off requests.
module range_allocator_coalescing_top #(
   parameter int RANGES_MAX = rac_pkg::RANGES_MAX
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rac_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rac_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [rac_pkg::CNT_W-1:0] csr_wdata
);
   import rac_pkg::*;

   localparam int UW = $clog2(RANGES_MAX + 1);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]       state_ff, state_in;
   req_type_type     req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] heap_ff, total_ff, total_in, size_c;
   logic [UW-1:0]    used_ff, used_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic             exact_ff;
   ctl_type          ctl;

   nbr_type nbr [RANGES_MAX+2];
   logic    le_chain [RANGES_MAX+2];
   logic    upto_chain [RANGES_MAX+1];
   rpt_type rpt [RANGES_MAX];
   rpt_type red;
   logic    csr_fire, req_fire;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (csr_wdata == '0) size_c = CNT_W'(1);
      else if (csr_wdata > CNT_W'(SLOTS_MAX)) size_c = CNT_W'(SLOTS_MAX);
      else size_c = csr_wdata;
   end

   assign ctl = '{capture: state_ff == S_EVAL, apply: state_ff == S_APPLY,
                  cmd: cmd_ff, exact: exact_ff, cnt: req_ff.count,
                  off: req_ff.range_offset, reload: csr_fire, size: size_c};

   // row ends: a virtual left neighbor below every offset, nothing on the right
   assign nbr[0]              = '{valid: 1'b0, start: '0, len: '0, le_q: 1'b1, upto_q: 1'b0};
   assign nbr[RANGES_MAX+1]   = '0;
   assign le_chain[0]            = 1'b1;
   assign le_chain[RANGES_MAX+1] = 1'b0;
   assign upto_chain[0]          = 1'b0;

   for (genvar g = 0; g < RANGES_MAX; g++) begin : g_cell
      rac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .is_first  (g == 0),
         .ctl       (ctl),
         .prev_nbr  (nbr[g]),
         .next_nbr  (nbr[g+2]),
         .prev_le_c (le_chain[g]),
         .next_le_c (le_chain[g+2]),
         .upto_in   (upto_chain[g]),
         .le_c      (le_chain[g+1]),
         .upto_out  (upto_chain[g+1]),
         .own_nbr   (nbr[g+1]),
         .rpt       (rpt[g])
      );
   end

   always_comb begin
      red = '0;
      for (int i = 0; i < RANGES_MAX; i++) red = red | rpt[i];
   end

   // decide the response and the row command in the compare cycle
   always_comb begin
      logic [CNT_W:0] off_end;
      off_end  = {2'b00, req_ff.range_offset} + {1'b0, req_ff.count};
      rsp_in   = '{resp_kind: req_ff.req_type, status: ST_OK, alloc_offset: '0,
                   free_total: total_ff};
      cmd_in   = CMD_HOLD;
      total_in = total_ff;
      used_in  = used_ff;
      if (req_ff.count == '0) begin
         cmd_in = CMD_HOLD;
      end else if (req_ff.req_type == KIND_ALLOC) begin
         if (req_ff.count > total_ff) begin
            rsp_in.status = ST_TOO_SMALL;
         end else if (!upto_chain[RANGES_MAX]) begin
            rsp_in.status = ST_NO_RANGE;
         end else begin
            cmd_in              = CMD_ALLOC;
            rsp_in.alloc_offset = red.offset;
            total_in            = total_ff - req_ff.count;
            if (red.exact) used_in = used_ff - UW'(1);
         end
      end else begin
         if (off_end > {1'b0, heap_ff} || red.left_gt || red.right_gt) begin
            rsp_in.status = ST_NO_RANGE;
         end else if (red.left_eq && red.right_eq) begin
            cmd_in  = CMD_BOTH;
            used_in = used_ff - UW'(1);
         end else if (red.left_eq) begin
            cmd_in = CMD_LEFT;
         end else if (red.right_eq) begin
            cmd_in = CMD_RIGHT;
         end else if (used_ff == UW'(RANGES_MAX)) begin
            rsp_in.status = ST_NO_RANGE;
         end else begin
            cmd_in  = CMD_INSERT;
            used_in = used_ff + UW'(1);
         end
         if (rsp_in.status == ST_OK) total_in = total_ff + req_ff.count;
      end
      rsp_in.free_total = total_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_EVAL;
         S_EVAL:  state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         heap_ff      <= CNT_W'(SLOTS_MAX);
         total_ff     <= CNT_W'(SLOTS_MAX);
         used_ff      <= UW'(1);
         cmd_ff       <= CMD_HOLD;
         exact_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_fire) begin
            heap_ff  <= size_c;
            total_ff <= size_c;
            used_ff  <= UW'(1);
         end else if (state_ff == S_EVAL) begin
            total_ff <= total_in;
            used_ff  <= used_in;
            cmd_ff   <= cmd_in;
            exact_ff <= red.exact;
         end
         if (state_ff == S_APPLY) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_data;
      if (state_ff == S_EVAL) rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/rac_checker.sv =====
// Port-level checks for the range allocator, bound to the top level.
// Depends on rac_pkg and range_allocator_coalescing_top.
module rac_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rac_pkg::rsp_type      rsp_data
);
   import rac_pkg::*;

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.resp_kind == KIND_FREE || rsp_data.status != ST_OK)
      |-> rsp_data.alloc_offset == '0)
      else $error("offset set on a response without a grant");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_total <= CNT_W'(SLOTS_MAX) && rsp_data.status != 2'd3)
      else $error("response total or status out of range");

endmodule

bind range_allocator_coalescing_top rac_checker u_rac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/range_allocator_coalescing_checker.sv =====
// Checker for the range allocator: watches the request, response and csr channels,
// keeps its own free-range table and compares every response word.
// Depends on rac_pkg.
`timescale 1ns / 100ps

module range_allocator_coalescing_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  rac_pkg::req_type_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rac_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [rac_pkg::CNT_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);
   import rac_pkg::*;

   int free_start[$];
   int free_len[$];
   int total_free;
   int heap_slots;
   rsp_type expected_rsp[$];

   function automatic void reload_table(int size);
      if (size == 0) size = 1;
      if (size > SLOTS_MAX) size = SLOTS_MAX;
      heap_slots = size;
      free_start = {0};
      free_len = {size};
      total_free = size;
   endfunction

   function automatic rsp_type predict_response(req_type_type req);
      rsp_type r;
      int cnt, off, i, pos;
      bit has_left, has_right, join_left, join_right;
      cnt = req.count;
      off = req.range_offset;
      r.resp_kind = req.req_type;
      r.status = ST_OK;
      r.alloc_offset = '0;
      if (req.req_type == KIND_ALLOC) begin
         if (cnt == 0) begin
         end else if (cnt > total_free) begin
            r.status = ST_TOO_SMALL;
         end else begin
            r.status = ST_NO_RANGE;
            for (i = 0; i < free_len.size(); i++) begin
               if (free_len[i] >= cnt) begin
                  r.alloc_offset = OFF_W'(free_start[i] + free_len[i] - cnt);
                  if (free_len[i] == cnt) begin
                     free_start.delete(i);
                     free_len.delete(i);
                  end else begin
                     free_len[i] -= cnt;
                  end
                  total_free -= cnt;
                  r.status = ST_OK;
                  break;
               end
            end
         end
      end else if (cnt != 0) begin
         pos = 0;
         while (pos < free_start.size() && free_start[pos] <= off) pos++;
         has_left = pos > 0;
         has_right = pos < free_start.size();
         if (off + cnt > heap_slots) r.status = ST_NO_RANGE;
         else if (has_left && free_start[pos-1] + free_len[pos-1] > off) r.status = ST_NO_RANGE;
         else if (has_right && off + cnt > free_start[pos]) r.status = ST_NO_RANGE;
         else begin
            join_left = has_left && free_start[pos-1] + free_len[pos-1] == off;
            join_right = has_right && off + cnt == free_start[pos];
            if (join_left) begin
               free_len[pos-1] += cnt;
               if (join_right) begin
                  free_len[pos-1] += free_len[pos];
                  free_start.delete(pos);
                  free_len.delete(pos);
               end
            end else if (join_right) begin
               free_start[pos] = off;
               free_len[pos] += cnt;
            end else if (free_start.size() >= RANGES_MAX) begin
               r.status = ST_NO_RANGE;
            end else begin
               free_start.insert(pos, off);
               free_len.insert(pos, cnt);
            end
            if (r.status == ST_OK) total_free += cnt;
         end
      end
      r.free_total = CNT_W'(total_free);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         reload_table(SLOTS_MAX);
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) reload_table(csr_wdata);
         if (req_valid && req_ready) expected_rsp.push_back(predict_response(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response word %h", rsp_data);
               fail_count++;
            end else begin
               exp_rsp = expected_rsp.pop_front();
               if (rsp_data.resp_kind !== exp_rsp.resp_kind) begin
                  $error("resp_kind expected %0d actual %0d", exp_rsp.resp_kind,
                         rsp_data.resp_kind);
                  fail_count++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.alloc_offset !== exp_rsp.alloc_offset) begin
                  $error("alloc_offset expected %0d actual %0d", exp_rsp.alloc_offset,
                         rsp_data.alloc_offset);
                  fail_count++;
               end
               if (rsp_data.free_total !== exp_rsp.free_total) begin
                  $error("free_total expected %0d actual %0d", exp_rsp.free_total,
                         rsp_data.free_total);
                  fail_count++;
               end
            end
         end
      end
      pending_count <= expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      reload_table(SLOTS_MAX);
   end

endmodule

// ===== tb/range_allocator_coalescing_top_test.sv =====
// Testbench top for the range allocator: clock, reset, request and csr stimulus
// with random gaps, response stalls and the verdict. Depends on rac_pkg, the block
// and range_allocator_coalescing_checker.
`timescale 1ns / 100ps

module range_allocator_coalescing_top_test;
   import rac_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [CNT_W-1:0] csr_wdata;
   int           fail_count;
   int           pending_count;
   bit           stim_done;

   // model of what the block holds, to aim frees at allocated ranges
   int held_off[$];
   int held_cnt[$];
   int last_alloc_cnt[$];
   int cur_heap;

   range_allocator_coalescing_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   range_allocator_coalescing_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // stall the response side at random
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (stim_done) rsp_ready <= 1'b1;
      else rsp_ready <= gap_length() == 0 || $urandom_range(0, 2) == 0;
   end

   task automatic drain();
      do @(posedge clock); while (pending_count != 0 || rsp_valid);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_heap(int size);
      csr_wdata <= size[CNT_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      held_off.delete();
      held_cnt.delete();
      cur_heap = (size == 0) ? 1 : (size > SLOTS_MAX ? SLOTS_MAX : size);
   endtask

   // send one word; valid drops between words
   task automatic send_word(logic kind, int cnt, int off);
      int gap;
      gap = gap_length();
      repeat (gap + 1) @(posedge clock);
      req_data <= '{req_type: kind, count: cnt[CNT_W-1:0], range_offset: off[OFF_W-1:0]};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
   endtask

   // record granted allocations so later frees hit real ranges
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_data.resp_kind == KIND_ALLOC
          && rsp_data.status == ST_OK && last_alloc_cnt.size() != 0) begin
         if (last_alloc_cnt[0] != 0) begin
            held_off.push_back(rsp_data.alloc_offset);
            held_cnt.push_back(last_alloc_cnt[0]);
         end
      end
      if (!reset && rsp_valid && rsp_ready && rsp_data.resp_kind == KIND_ALLOC
          && last_alloc_cnt.size() != 0)
         void'(last_alloc_cnt.pop_front());
      if (!reset && req_valid && req_ready && req_data.req_type == KIND_ALLOC)
         last_alloc_cnt.push_back(req_data.count);
   end

   task automatic random_phase(int items);
      int i, idx, pick, cnt, part;
      for (i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(1, cur_heap / 8 + 2);
            send_word(KIND_ALLOC, cnt, $urandom_range(0, 1023));
         end else if (pick < 85 && held_off.size() != 0) begin
            idx = $urandom_range(0, held_off.size() - 1);
            // free the whole range or a piece of either end
            part = $urandom_range(0, 3);
            if (part == 0 && held_cnt[idx] > 1) begin
               cnt = $urandom_range(1, held_cnt[idx] - 1);
               send_word(KIND_FREE, cnt, held_off[idx]);
               held_off[idx] += cnt;
               held_cnt[idx] -= cnt;
            end else if (part == 1 && held_cnt[idx] > 1) begin
               cnt = $urandom_range(1, held_cnt[idx] - 1);
               send_word(KIND_FREE, cnt, held_off[idx] + held_cnt[idx] - cnt);
               held_cnt[idx] -= cnt;
            end else begin
               send_word(KIND_FREE, held_cnt[idx], held_off[idx]);
               held_off.delete(idx);
               held_cnt.delete(idx);
            end
         end else begin
            // noise: double frees, out-of-heap frees, zero counts
            send_word(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                      $urandom_range(0, 1023));
         end
         if (i % 25 == 24) drain();
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      rsp_ready = 1'b0;
      stim_done = 1'b0;
      cur_heap = SLOTS_MAX;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and special cases on the reset heap
      send_word(KIND_ALLOC, 0, 1023);
      send_word(KIND_ALLOC, 2047, 0);
      send_word(KIND_ALLOC, 1024, 0);
      send_word(KIND_FREE, 0, 5);
      send_word(KIND_FREE, 1024, 0);
      send_word(KIND_FREE, 2, 1023);
      send_word(KIND_ALLOC, 100, 0);
      send_word(KIND_ALLOC, 100, 0);
      send_word(KIND_ALLOC, 100, 0);
      send_word(KIND_FREE, 100, 824);
      send_word(KIND_FREE, 50, 724);
      send_word(KIND_FREE, 50, 774);
      send_word(KIND_FREE, 10, 900);
      send_word(KIND_FREE, 100, 624);
      send_word(KIND_ALLOC, 1, 0);
      send_word(KIND_ALLOC, 1023, 0);
      send_word(KIND_ALLOC, 1, 0);
      send_word(KIND_FREE, 1, 0);
      send_word(KIND_FREE, 1, 1023);
      drain();
      // hole in middle: no contiguous range while total suffices
      write_heap(10);
      send_word(KIND_ALLOC, 4, 0);
      send_word(KIND_ALLOC, 3, 0);
      send_word(KIND_FREE, 4, 6);
      send_word(KIND_ALLOC, 5, 0);
      drain();
      write_heap(0);
      send_word(KIND_ALLOC, 1, 0);
      send_word(KIND_ALLOC, 1, 0);
      drain();
      write_heap(2047);
      random_phase(150);
      drain();
      write_heap(1);
      random_phase(30);
      drain();
      write_heap($urandom_range(2, 1023));
      random_phase(150);
      drain();
      write_heap(1024);
      random_phase(170);
      drain();
      stim_done = 1'b1;
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
